### rtl/eplf_pkg.sv
// Package for the egress port allowlist filter.
// Holds the frame capture and result types, ethertypes, protocol numbers and codes.
// No dependencies.
package eplf_pkg;

  localparam int PORT_SLOTS = 12;
  localparam int PORT_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int SLOTS_W    = 4;
  localparam int OFF_W      = 7;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam logic [OFF_W-1:0] OFF_MAX = 7'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALLOW_FIRST  = 2'd0,
    REG_ALLOW_SECOND = 2'd1,
    REG_ALLOW_THIRD  = 2'd2,
    REG_SLOTS_IN_USE = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_TCP_V4 = 3'd1,
    CLS_UDP_V4 = 3'd2,
    CLS_TCP_V6 = 3'd3,
    CLS_UDP_V6 = 3'd4
  } proto_class_t;

  typedef logic [PORT_SLOTS-1:0][PORT_W-1:0] slot_ports_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [15:0]      ethertype;
    logic [7:0]       v4_protocol;
    logic [7:0]       v6_next_header;
    logic [63:0]      addr_high;
    logic [63:0]      addr_low;
    logic [15:0]      v4_port;
    logic [15:0]      v6_port;
    logic [63:0]      arp;
  } frame_t;

  typedef struct packed {
    logic              verdict;
    logic              event_valid;
    logic [15:0]       ethertype;
    proto_class_t      proto_class;
    logic [PORT_W-1:0] dest_port;
    logic [63:0]       address_high;
    logic [63:0]       address_low;
    logic [63:0]       arp_words;
  } result_t;

endpackage

### rtl/eplf_capture.sv
// Per-frame capture registers of the egress port allowlist filter.
// Tracks the byte offset and collects header fields; shows the state including the current word.
// Depends on eplf_pkg.
module eplf_capture import eplf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] frame_byte,
  input  logic       last_byte,
  output frame_t     frame_cur,
  output frame_t     frame_held
);

  frame_t st_r;
  frame_t st_nxt;
  frame_t frame_cap;
  logic [OFF_W-1:0] off;

  assign off = st_r.offset;

  always_comb begin
    frame_cap = st_r;
    if (off == 7'd12) begin
      frame_cap.ethertype[15:8] = frame_byte;
    end
    if (off == 7'd13) begin
      frame_cap.ethertype[7:0] = frame_byte;
    end
    if (off >= 7'd14 && off <= 7'd21) begin
      frame_cap.arp[{3'(7'd21 - off), 3'b000} +: 8] = frame_byte;
    end
    if (st_r.ethertype == ETYPE_IPV4) begin
      if (off == 7'd23) begin
        frame_cap.v4_protocol = frame_byte;
      end else if (off >= 7'd30 && off <= 7'd33) begin
        frame_cap.addr_high[{1'b1, 2'(7'd33 - off), 3'b000} +: 8] = frame_byte;
      end else if (off == 7'd36) begin
        frame_cap.v4_port[15:8] = frame_byte;
      end else if (off == 7'd37) begin
        frame_cap.v4_port[7:0] = frame_byte;
      end
    end else if (st_r.ethertype == ETYPE_IPV6) begin
      if (off == 7'd20) begin
        frame_cap.v6_next_header = frame_byte;
      end else if (off >= 7'd38 && off <= 7'd45) begin
        frame_cap.addr_high[{3'(7'd45 - off), 3'b000} +: 8] = frame_byte;
      end else if (off >= 7'd46 && off <= 7'd53) begin
        frame_cap.addr_low[{3'(7'd53 - off), 3'b000} +: 8] = frame_byte;
      end else if (off == 7'd56) begin
        frame_cap.v6_port[15:8] = frame_byte;
      end else if (off == 7'd57) begin
        frame_cap.v6_port[7:0] = frame_byte;
      end
    end
  end

  always_comb begin
    st_nxt        = frame_cap;
    st_nxt.offset = (off < OFF_MAX) ? off + 7'd1 : OFF_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      if (last_byte) begin
        st_r <= '0;
      end else begin
        st_r <= st_nxt;
      end
    end
  end

  assign frame_cur  = frame_cap;
  assign frame_held = st_r;

endmodule

### rtl/eplf_verdict.sv
// Frame classification and allowlist match of the egress port allowlist filter.
// Turns the captured header fields of a finished frame into one result word.
// Depends on eplf_pkg.
module eplf_verdict import eplf_pkg::*; (
  input  frame_t               frame,
  input  slot_ports_t          slot_ports,
  input  logic [SLOTS_W-1:0]   slots_in_use,
  output result_t              result
);

  logic [OFF_W:0]    len;
  logic              v4_tcp, v4_udp, v6_tcp, v6_udp;
  logic              is_v4, is_v6, is_arp;
  logic              port_hit;
  logic [PORT_W-1:0] port;

  assign len    = {1'b0, frame.offset} + 8'd1;
  assign is_v4  = (frame.ethertype == ETYPE_IPV4) && (len >= 8'd34);
  assign is_v6  = (frame.ethertype == ETYPE_IPV6) && (len >= 8'd54);
  assign is_arp = (frame.ethertype == ETYPE_ARP);
  assign v4_tcp = (frame.v4_protocol == PROTO_TCP) && (len >= 8'd54);
  assign v4_udp = (frame.v4_protocol == PROTO_UDP) && (len >= 8'd42);
  assign v6_tcp = (frame.v6_next_header == PROTO_TCP) && (len >= 8'd74);
  assign v6_udp = (frame.v6_next_header == PROTO_UDP) && (len >= 8'd62);

  always_comb begin
    result             = '0;
    result.event_valid = 1'b1;
    result.ethertype   = frame.ethertype;
    result.proto_class = CLS_NONE;
    port               = '0;
    if (is_v4) begin
      if (v4_tcp || v4_udp) begin
        result.proto_class  = v4_tcp ? CLS_TCP_V4 : CLS_UDP_V4;
        port                = frame.v4_port;
        result.address_high = frame.addr_high;
      end else begin
        result.event_valid = 1'b0;
      end
    end else if (is_v6) begin
      if (v6_tcp || v6_udp) begin
        result.proto_class  = v6_tcp ? CLS_TCP_V6 : CLS_UDP_V6;
        port                = frame.v6_port;
        result.address_high = frame.addr_high;
        result.address_low  = frame.addr_low;
      end else begin
        result.event_valid = 1'b0;
      end
    end else if (is_arp && len >= 8'd22) begin
      result.arp_words = frame.arp;
    end

    port_hit = 1'b0;
    for (int k = 0; k < PORT_SLOTS; k++) begin
      if (slots_in_use > SLOTS_W'(k) && slot_ports[k] == port) begin
        port_hit = 1'b1;
      end
    end

    result.dest_port = port;
    result.verdict   = is_arp || port_hit;
    if (!result.event_valid) begin
      result = '0;
    end
  end

endmodule

### rtl/egress_port_allowlist_filter.sv
// Top level of the egress port allowlist filter.
// Input word register, configuration registers, result register; uses eplf_capture, eplf_verdict.
// Depends on eplf_pkg.

// The filter takes one frame byte per clock unless stalled and gives one result word per frame
// once its last byte is accepted: the byte passes the input register, where it is captured and,
// on the last byte, the frame is classified and matched against the port slots, and then the
// result register. Bytes that are not last never wait. A last byte waits in the input register
// only while the previous result is still held by a stalled output, so the rate is one byte per
// clock while the output is not stalled. Configuration writes take effect at the next clock; the
// user must make them only while no frame is in flight, and the block does not enforce this.
module egress_port_allowlist_filter import eplf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_frame_byte,
  input  logic                   in_last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_verdict,
  output logic                   out_event_valid,
  output logic [15:0]            out_frame_ethertype,
  output logic [2:0]             out_proto_class,
  output logic [PORT_W-1:0]      out_destination_port,
  output logic [63:0]            out_address_high,
  output logic [63:0]            out_address_low,
  output logic [63:0]            out_arp_words
);

  logic [63:0]        allow_first_r, allow_second_r, allow_third_r;
  logic [SLOTS_W-1:0] slots_in_use_r;
  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  logic               in_last_r;
  logic               out_valid_r;
  result_t            out_r;
  logic               step;
  logic               out_free;
  frame_t             frame_cur;
  frame_t             frame_held;
  result_t            result;
  slot_ports_t        slot_ports;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_first_r  <= '0;
      allow_second_r <= '0;
      allow_third_r  <= '0;
      slots_in_use_r <= 4'd10;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ALLOW_FIRST:  allow_first_r  <= cfg_wdata;
        REG_ALLOW_SECOND: allow_second_r <= cfg_wdata;
        REG_ALLOW_THIRD:  allow_third_r  <= cfg_wdata;
        REG_SLOTS_IN_USE: slots_in_use_r <= cfg_wdata[SLOTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign slot_ports = slot_ports_t'({allow_third_r, allow_second_r, allow_first_r});

  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && (!in_last_r || out_free);
  assign in_stall = in_valid_r && !step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_frame_byte;
      in_last_r <= in_last_byte;
    end
  end

  eplf_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .frame_byte (in_byte_r),
    .last_byte  (in_last_r),
    .frame_cur  (frame_cur),
    .frame_held (frame_held)
  );

  eplf_verdict u_verdict (
    .frame        (frame_cur),
    .slot_ports   (slot_ports),
    .slots_in_use (slots_in_use_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      out_r <= result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_verdict          = out_r.verdict;
  assign out_event_valid      = out_r.event_valid;
  assign out_frame_ethertype  = out_r.ethertype;
  assign out_proto_class      = out_r.proto_class;
  assign out_destination_port = out_r.dest_port;
  assign out_address_high     = out_r.address_high;
  assign out_address_low      = out_r.address_low;
  assign out_arp_words        = out_r.arp_words;

  a_stall_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && in_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked last word");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_last_r) |=> (frame_held.offset == '0 && frame_held.ethertype == '0))
    else $error("frame state not cleared after last word");

  a_dropped_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_event_valid) |->
      (!out_verdict && out_proto_class == CLS_NONE && out_destination_port == '0))
    else $error("discarded result carries nonzero fields");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_last_r) |=> out_valid)
    else $error("last word did not produce a result");

endmodule
